// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_BUILD,
        ST_IDLE,
        ST_DECODE,
        ST_FCHK,
        ST_MCHK0,
        ST_MCHK1,
        ST_MMERGE,
        ST_FDONE,
        ST_SCAN,
        ST_SPLIT,
        ST_DONE,
        ST_TO_RD,
        ST_TO_WR,
        ST_PO_RD,
        ST_PO_UNL,
        ST_PO_PUSH,
        ST_PO_LINK
    } st_t;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ===== hdl/buddy_page_allocator_unit.sv =====
// Buddy page allocator.
// Input channel (in_valid/in_ready) carries op, page_count, page_index; the
// output channel (out_valid/out_ready) returns status, page_index_res,
// block_order and free_total, one result per request, in order.
// region_pages_we writes the region size; write it only while idle. A write
// restarts the region: the page meta memory is cleared and then rebuilt
// greedily. Reset does the same.
// in_ready is high only while the sequencer is idle. A bad size or a double
// free is reported as bad. An allocate skips empty orders and splits the block
// it finds down to the request order (no free block: full status). A free
// merges with its buddy while that buddy lies in the region and is free at
// the same order.
// Each step is paced by the single-port page record memories (one access per
// cycle) and the one shared span unit (block size, buddy, end compare).
// A result sits in an output register; the next request is accepted while it
// waits, and the sequencer holds its next result until the register drains.
module buddy_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES   = 1024,
    parameter int ORDER_COUNT = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             region_pages_we,
    input  logic [$clog2(NUM_PAGES):0]       region_pages,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [$clog2(NUM_PAGES):0]       page_count,
    input  logic [$clog2(NUM_PAGES)-1:0]     page_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [$clog2(NUM_PAGES)-1:0]     page_index_res,
    output logic [$clog2(ORDER_COUNT+1)-1:0] block_order,
    output logic [$clog2(NUM_PAGES):0]       free_total
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OW     = $clog2(ORDER_COUNT + 1);
    localparam int LIDX_W = $clog2(ORDER_COUNT);
    localparam int SW     = CNT_W + ORDER_COUNT;
    localparam int META_W = OW + 1;
    localparam logic [CNT_W-1:0] NIL = CNT_W'(NUM_PAGES);

    // Sequencer and request registers
    st_t               state_reg, state_next;
    st_t               ret_reg, ret_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  region_reg, region_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    logic              op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [OW-1:0]     k_reg, k_next;
    logic              bad_reg, bad_next;
    logic [OW-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]  page_reg, page_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [OW-1:0]     o_reg, o_next;
    logic [IDX_W-1:0]  bud_reg, bud_next;
    logic [IDX_W-1:0]  sp_reg, sp_next;
    logic [OW-1:0]     so_reg, so_next;
    logic [CNT_W-1:0]  oh_reg, oh_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [OW-1:0]     rord_reg, rord_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    logic [OW-1:0]     oord_reg, oord_next;
    logic [CNT_W-1:0]  ofree_reg, ofree_next;

    // Per-order free lists
    logic [CNT_W-1:0]  lhead_reg [ORDER_COUNT];
    logic [CNT_W-1:0]  lhead_next [ORDER_COUNT];
    logic [CNT_W-1:0]  count_reg [ORDER_COUNT];
    logic [CNT_W-1:0]  count_next [ORDER_COUNT];
    logic [LIDX_W-1:0] lidx;
    logic [CNT_W-1:0]  lh_rd;
    logic [CNT_W-1:0]  cnt_rd;

    // Page record memories
    logic [IDX_W-1:0]  meta_addr, next_addr, prev_addr;
    logic              meta_we, next_we, prev_we;
    logic [META_W-1:0] meta_wd, meta_rd;
    logic [CNT_W-1:0]  next_wd, next_rd, prev_wd, prev_rd;

    // Unlink view of the record just read
    logic              rd_mark;
    logic [OW-1:0]     rd_ord;
    logic              unl_ok;
    logic [SW-1:0]     pow_mo, pow_so, pow_bo;

    // Shared span unit
    logic [IDX_W-1:0]  su_base;
    logic [OW-1:0]     su_ord;
    logic              su_bud;
    logic [SW-1:0]     su_sum;
    logic [IDX_W-1:0]  su_other;
    logic              su_over, su_misal, su_oor;

    logic [OW-1:0]     k_calc;
    logic [OW-1:0]     bo;

    bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta (
        .clk   (clk),
        .addr  (meta_addr),
        .we    (meta_we),
        .wdata (meta_wd),
        .rdata (meta_rd)
    );

    bpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_next (
        .clk   (clk),
        .addr  (next_addr),
        .we    (next_we),
        .wdata (next_wd),
        .rdata (next_rd)
    );

    bpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_prev (
        .clk   (clk),
        .addr  (prev_addr),
        .we    (prev_we),
        .wdata (prev_wd),
        .rdata (prev_rd)
    );

    bpa_span #(
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .OW     (OW),
        .SW     (SW),
        .NPAGES (NUM_PAGES)
    ) u_span (
        .base    (su_base),
        .ord     (su_ord),
        .use_bud (su_bud),
        .region  (region_reg),
        .sum     (su_sum),
        .other   (su_other),
        .over    (su_over),
        .misal   (su_misal),
        .oor     (su_oor)
    );

    assign rd_mark = meta_rd[OW];
    assign rd_ord  = meta_rd[OW-1:0];
    assign unl_ok  = rd_mark && (rd_ord < OW'(ORDER_COUNT));
    assign pow_mo  = SW'(1) << rd_ord;
    assign pow_so  = SW'(1) << so_reg;
    assign pow_bo  = SW'(1) << bo;

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign page_index_res = oidx_reg;
    assign block_order    = oord_reg;
    assign free_total     = ofree_reg;

    // Request order: smallest o with 2^o >= page_count
    always_comb
    begin
        k_calc = OW'(ORDER_COUNT);
        for (int o = ORDER_COUNT - 1; o >= 0; o--)
        begin
            if (SW'(page_count) <= (SW'(1) << o))
            begin
                k_calc = OW'(o);
            end
        end
    end

    // Greedy build order: largest o with 2^o <= remaining pages
    always_comb
    begin
        bo = '0;
        for (int o = 0; o < ORDER_COUNT; o++)
        begin
            if ((SW'(1) << o) <= SW'(n_reg))
            begin
                bo = OW'(o);
            end
        end
    end

    // Free list index for this cycle
    always_comb
    begin
        case (state_reg)
            ST_SCAN:              lidx = cur_reg[LIDX_W-1:0];
            ST_TO_WR, ST_PO_UNL:  lidx = rd_ord[LIDX_W-1:0];
            default:              lidx = so_reg[LIDX_W-1:0];
        endcase
        lh_rd  = lhead_reg[lidx];
        cnt_rd = count_reg[lidx];
    end

    // Span unit operand select
    always_comb
    begin
        su_base = idx_reg;
        su_ord  = k_reg;
        su_bud  = 1'b0;
        case (state_reg)
            ST_BUILD:
            begin
                su_base = off_reg[IDX_W-1:0];
                su_ord  = bo;
            end
            ST_MCHK0:
            begin
                su_base = base_reg;
                su_ord  = o_reg;
                su_bud  = 1'b1;
            end
            ST_SPLIT:
            begin
                su_base = page_reg;
                su_ord  = cur_reg - OW'(1);
            end
            default:
            begin
                su_base = idx_reg;
                su_ord  = k_reg;
            end
        endcase
    end

    // Next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        region_next    = region_reg;
        n_next         = n_reg;
        off_next       = off_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        bad_next       = bad_reg;
        cur_next       = cur_reg;
        page_next      = page_reg;
        base_next      = base_reg;
        o_next         = o_reg;
        bud_next       = bud_reg;
        sp_next        = sp_reg;
        so_next        = so_reg;
        oh_next        = oh_reg;
        rstat_next     = rstat_reg;
        ridx_next      = ridx_reg;
        rord_next      = rord_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg;
        ostat_next     = ostat_reg;
        oidx_next      = oidx_reg;
        oord_next      = oord_reg;
        ofree_next     = ofree_reg;
        lhead_next     = lhead_reg;
        count_next     = count_reg;

        // Output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    n_next     = region_reg;
                    off_next   = '0;
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (n_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sp_next    = off_reg[IDX_W-1:0];
                    so_next    = bo;
                    off_next   = su_sum[CNT_W-1:0];
                    n_next     = n_reg - pow_bo[CNT_W-1:0];
                    ret_next   = ST_BUILD;
                    state_next = ST_PO_RD;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    idx_next   = page_index;
                    k_next     = k_calc;
                    bad_next   = (page_count == '0) || (k_calc == OW'(ORDER_COUNT));
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ridx_next = '0;
                rord_next = '0;
                if (bad_reg)
                begin
                    rstat_next = STAT_BAD;
                    state_next = ST_DONE;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    cur_next   = k_reg;
                    state_next = ST_SCAN;
                end
                else if (su_misal || su_over)
                begin
                    rstat_next = STAT_BAD;
                    state_next = ST_DONE;
                end
                else
                begin
                    base_next  = idx_reg;
                    o_next     = k_reg;
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK:
            begin
                // double free
                if (rd_mark)
                begin
                    rstat_next = STAT_BAD;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MCHK0;
                end
            end
            ST_MCHK0:
            begin
                if ((o_reg >= OW'(ORDER_COUNT - 1)) || su_oor || su_over)
                begin
                    sp_next    = base_reg;
                    so_next    = o_reg;
                    ret_next   = ST_FDONE;
                    state_next = ST_PO_RD;
                end
                else
                begin
                    bud_next   = su_other;
                    state_next = ST_MCHK1;
                end
            end
            ST_MCHK1:
            begin
                if (!rd_mark || (rd_ord != o_reg))
                begin
                    sp_next    = base_reg;
                    so_next    = o_reg;
                    ret_next   = ST_FDONE;
                    state_next = ST_PO_RD;
                end
                else
                begin
                    sp_next    = bud_reg;
                    ret_next   = ST_MMERGE;
                    state_next = ST_TO_RD;
                end
            end
            ST_MMERGE:
            begin
                if (bud_reg < base_reg)
                begin
                    base_next = bud_reg;
                end
                o_next     = o_reg + OW'(1);
                state_next = ST_MCHK0;
            end
            ST_FDONE:
            begin
                rstat_next = STAT_OK;
                ridx_next  = base_reg;
                rord_next  = o_reg;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (cur_reg >= OW'(ORDER_COUNT))
                begin
                    rstat_next = STAT_FULL;
                    state_next = ST_DONE;
                end
                else if (lh_rd == NIL)
                begin
                    cur_next = cur_reg + OW'(1);
                end
                else
                begin
                    page_next  = lh_rd[IDX_W-1:0];
                    sp_next    = lh_rd[IDX_W-1:0];
                    ret_next   = ST_SPLIT;
                    state_next = ST_TO_RD;
                end
            end
            ST_SPLIT:
            begin
                if (cur_reg > k_reg)
                begin
                    // push the upper half one order down
                    cur_next   = cur_reg - OW'(1);
                    sp_next    = su_sum[IDX_W-1:0];
                    so_next    = cur_reg - OW'(1);
                    ret_next   = ST_SPLIT;
                    state_next = ST_PO_RD;
                end
                else
                begin
                    rstat_next = STAT_OK;
                    ridx_next  = page_reg;
                    rord_next  = k_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = rstat_reg;
                    oidx_next      = ridx_reg;
                    oord_next      = rord_reg;
                    ofree_next     = free_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_TO_RD, ST_PO_RD:
            begin
                state_next = (state_reg == ST_TO_RD) ? ST_TO_WR : ST_PO_UNL;
            end
            ST_TO_WR, ST_PO_UNL:
            begin
                // unlink the page from its list
                if (unl_ok)
                begin
                    if (prev_rd >= NIL)
                    begin
                        lhead_next[lidx] = next_rd;
                    end
                    if (cnt_rd != '0)
                    begin
                        count_next[lidx] = cnt_rd - CNT_W'(1);
                        free_next        = free_reg - pow_mo[CNT_W-1:0];
                    end
                end
                state_next = (state_reg == ST_TO_WR) ? ret_reg : ST_PO_PUSH;
            end
            ST_PO_PUSH:
            begin
                oh_next          = lh_rd;
                lhead_next[lidx] = CNT_W'(sp_reg);
                count_next[lidx] = cnt_rd + CNT_W'(1);
                free_next        = free_reg + pow_so[CNT_W-1:0];
                state_next       = ST_PO_LINK;
            end
            ST_PO_LINK:
            begin
                state_next = ret_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Region write restarts the region
        if (region_pages_we)
        begin
            region_next = (region_pages > NIL) ? NIL : region_pages;
            clr_next    = '0;
            free_next   = '0;
            state_next  = ST_CLEAR;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                lhead_next[i] = NIL;
                count_next[i] = '0;
            end
        end
    end

    // Page record memory controls
    always_comb
    begin
        meta_addr = sp_reg;
        meta_we   = 1'b0;
        meta_wd   = '0;
        next_addr = sp_reg;
        next_we   = 1'b0;
        next_wd   = '0;
        prev_addr = sp_reg;
        prev_we   = 1'b0;
        prev_wd   = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                meta_addr = clr_reg;
                meta_we   = 1'b1;
            end
            ST_DECODE:
            begin
                meta_addr = idx_reg;
            end
            ST_MCHK0:
            begin
                meta_addr = su_other;
            end
            ST_TO_WR, ST_PO_UNL:
            begin
                if (unl_ok)
                begin
                    meta_we = 1'b1;
                    meta_wd = {1'b0, rd_ord};
                    if (prev_rd < NIL)
                    begin
                        next_addr = prev_rd[IDX_W-1:0];
                        next_we   = 1'b1;
                        next_wd   = next_rd;
                    end
                    if (next_rd < NIL)
                    begin
                        prev_addr = next_rd[IDX_W-1:0];
                        prev_we   = 1'b1;
                        prev_wd   = prev_rd;
                    end
                end
            end
            ST_PO_PUSH:
            begin
                meta_we = 1'b1;
                meta_wd = {1'b1, so_reg};
                next_we = 1'b1;
                next_wd = lh_rd;
                prev_we = 1'b1;
                prev_wd = NIL;
            end
            ST_PO_LINK:
            begin
                if (oh_reg < NIL)
                begin
                    prev_addr = oh_reg[IDX_W-1:0];
                    prev_we   = 1'b1;
                    prev_wd   = CNT_W'(sp_reg);
                end
            end
            default:
            begin
                meta_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_IDLE;
            clr_reg       <= '0;
            region_reg    <= NIL;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                lhead_reg[i] <= NIL;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            region_reg    <= region_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            lhead_reg     <= lhead_next;
            count_reg     <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        off_reg   <= off_next;
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        bad_reg   <= bad_next;
        cur_reg   <= cur_next;
        page_reg  <= page_next;
        base_reg  <= base_next;
        o_reg     <= o_next;
        bud_reg   <= bud_next;
        sp_reg    <= sp_next;
        so_reg    <= so_next;
        oh_reg    <= oh_next;
        rstat_reg <= rstat_next;
        ridx_reg  <= ridx_next;
        rord_reg  <= rord_next;
        ostat_reg <= ostat_next;
        oidx_reg  <= oidx_next;
        oord_reg  <= oord_next;
        ofree_reg <= ofree_next;
    end

    // Failed requests report a zero block
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (page_index_res == '0 && block_order == '0))
        else $error("error result carries a block");

    // A good result names a real order
    a_ord_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_OK) |-> (block_order < OW'(ORDER_COUNT)))
        else $error("result order out of range");

    // An accepted transaction starts decode
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !region_pages_we) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

endmodule

// ===== hdl/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read-first, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/bpa_span.sv =====
module bpa_span #(
    parameter int IDX_W  = 10,
    parameter int CNT_W  = 11,
    parameter int OW     = 4,
    parameter int SW     = 22,
    parameter int NPAGES = 1024
) (
    input  logic [IDX_W-1:0] base,
    input  logic [OW-1:0]    ord,
    input  logic             use_bud,
    input  logic [CNT_W-1:0] region,
    output logic [SW-1:0]    sum,
    output logic [IDX_W-1:0] other,
    output logic             over,
    output logic             misal,
    output logic             oor
);

    logic [SW-1:0] pow;
    logic [SW-1:0] base_w;
    logic [SW-1:0] other_w;
    logic [SW-1:0] opnd;

    // Block size, buddy address, block end and range checks
    always_comb
    begin
        pow     = SW'(1) << ord;
        base_w  = SW'(base);
        other_w = base_w ^ pow;
        opnd    = use_bud ? other_w : base_w;
        sum     = opnd + pow;
        over    = sum > SW'(region);
        misal   = |(base_w & (pow - SW'(1)));
        oor     = other_w >= SW'(NPAGES);
        other   = other_w[IDX_W-1:0];
    end

endmodule
